[rtl/core/rtat_pkg.sv]
// shared types and constants for the ray triangle area test
`default_nettype none
package rtat_pkg;

    localparam int FIELD_W   = 63;
    localparam int NUM_IN    = 6;
    localparam int S_DATA_W  = 384;
    localparam int M_DATA_W  = 8;
    localparam int TOL_W     = 20;
    localparam logic [TOL_W-1:0] TOL_RESET = 20'd1;

    // pipeline control that travels beside the data
    typedef struct packed {
        logic valid;
        logic back_facing;
    } t_ctl;

    // next axis index, wrapping x,y,z
    function automatic int nxt(input int k);
        int r;
        r = (k == 2) ? 0 : k + 1;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/rtat_geom.sv]
// geometry pipeline: relative vertices, facing test, cross products, determinants
`default_nettype none
module rtat_geom #(
    parameter int CW = 21
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [rtat_pkg::S_DATA_W-1:0] i_data,
    output rtat_pkg::t_ctl                   o_ctl,
    output logic signed [3*CW+6:0]           o_det [3],
    output logic [2*CW-1:0]                  o_dd
);
    import rtat_pkg::*;

    localparam int VW  = CW + 1;
    localparam int PW  = 2 * VW;
    localparam int CXW = PW + 1;
    localparam int DPW = CW + CXW;
    localparam int DTW = DPW + 4;
    localparam int FW  = 2 * CW + 2;
    localparam int DDW = 2 * CW;

    logic signed [CW-1:0]  w_pt [4][3];
    logic signed [CW-1:0]  w_dir [3];
    logic signed [CW-1:0]  w_nrm [3];

    // stage 1
    logic                  r1_vld;
    logic signed [VW-1:0]  r1_v [3][3];
    logic signed [CW-1:0]  r1_d [3];
    logic signed [CW-1:0]  r1_n [3];
    // stage 2
    logic                  r2_vld;
    logic signed [2*CW-1:0] r2_dn [3];
    logic signed [2*CW-1:0] r2_d2 [3];
    logic signed [PW-1:0]  r2_pa [3][3];
    logic signed [PW-1:0]  r2_pb [3][3];
    logic signed [CW-1:0]  r2_d [3];
    // stage 3
    logic                  r3_vld;
    logic signed [FW-1:0]  r3_facing;
    logic [DDW-1:0]        r3_dd;
    logic signed [CXW-1:0] r3_c [3][3];
    logic signed [CW-1:0]  r3_d [3];
    // stage 4
    logic                  r4_vld;
    logic                  r4_back;
    logic [DDW-1:0]        r4_dd;
    logic signed [DPW-1:0] r4_dc [3][3];
    // stage 5
    logic                  r5_vld;
    logic                  r5_back;
    logic [DDW-1:0]        r5_dd;
    logic signed [DTW-1:0] r5_det [3];

    always_comb begin
        for (int f = 0; f < 4; f++) begin
            for (int k = 0; k < 3; k++) begin
                w_pt[f][k] = i_data[FIELD_W*f + CW*k +: CW];
            end
        end
        for (int k = 0; k < 3; k++) begin
            w_dir[k] = i_data[FIELD_W*4 + CW*k +: CW];
            w_nrm[k] = i_data[FIELD_W*5 + CW*k +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_v[i][k] <= VW'(w_pt[i][k]) - VW'(w_pt[3][k]);
                end
            end
            r1_d <= w_dir;
            r1_n <= w_nrm;

            // det i uses vertex pair (i+1, i+2)
            for (int k = 0; k < 3; k++) begin
                r2_dn[k] <= r1_d[k] * r1_n[k];
                r2_d2[k] <= r1_d[k] * r1_d[k];
            end
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_pa[i][k] <= r1_v[nxt(i)][nxt(k)] * r1_v[nxt(nxt(i))][nxt(nxt(k))];
                    r2_pb[i][k] <= r1_v[nxt(i)][nxt(nxt(k))] * r1_v[nxt(nxt(i))][nxt(k)];
                end
            end
            r2_d <= r1_d;

            r3_facing <= FW'(r2_dn[0]) + FW'(r2_dn[1]) + FW'(r2_dn[2]);
            r3_dd     <= DDW'(r2_d2[0]) + DDW'(r2_d2[1]) + DDW'(r2_d2[2]);
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r3_c[i][k] <= CXW'(r2_pa[i][k]) - CXW'(r2_pb[i][k]);
                end
            end
            r3_d <= r2_d;

            r4_back <= ~r3_facing[FW-1];
            r4_dd   <= r3_dd;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_dc[i][k] <= r3_d[k] * r3_c[i][k];
                end
            end

            r5_back <= r4_back;
            r5_dd   <= r4_dd;
            for (int i = 0; i < 3; i++) begin
                r5_det[i] <= DTW'(r4_dc[i][0]) + DTW'(r4_dc[i][1]) + DTW'(r4_dc[i][2]);
            end
        end
    end

    assign o_ctl.valid       = r5_vld;
    assign o_ctl.back_facing = r5_back;
    assign o_det             = r5_det;
    assign o_dd              = r5_dd;

endmodule
`default_nettype wire

[rtl/core/rtat_cmp.sv]
// area mismatch and exact squared tolerance compare
`default_nettype none
module rtat_cmp #(
    parameter int CW = 21,
    parameter int FB = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  rtat_pkg::t_ctl                   i_ctl,
    input  wire logic signed [3*CW+6:0]      i_det [3],
    input  wire logic [2*CW-1:0]             i_dd,
    input  wire logic [rtat_pkg::TOL_W-1:0]  i_tol,
    output rtat_pkg::t_ctl                   o_ctl,
    output logic                             o_hit
);
    import rtat_pkg::*;

    localparam int DTW  = 3 * CW + 7;
    localparam int SUMW = DTW + 2;
    localparam int MW   = DTW + 2;
    localparam int DDW  = 2 * CW;
    localparam int LIM  = TOL_W + 1 + FB + CW;
    localparam int MXW  = (MW > LIM) ? MW : LIM;
    localparam int MH   = (LIM + 1) / 2;
    localparam int HW   = LIM - MH;
    localparam int LW   = 2 * LIM;
    localparam int TTW  = 2 * TOL_W;
    localparam int SH   = 2 * (FB + 1);

    logic [TTW-1:0]          r_tt;
    logic [MXW-1:0]          w_mext;

    logic [5:0]              r_vld;
    logic [5:0]              r_back;
    logic [DDW-1:0]          r1_dd, r2_dd, r3_dd;
    logic [DTW-1:0]          r1_abs [3];
    logic signed [SUMW-1:0]  r1_sum;
    logic [MW-1:0]           r2_sa;
    logic [SUMW-1:0]         r2_as;
    logic [MW-1:0]           r3_m;
    logic                    r4_big, r5_big;
    logic [2*MH-1:0]         r4_ll;
    logic [MH+HW-1:0]        r4_lh;
    logic [2*HW-1:0]         r4_hh;
    logic [TOL_W+CW-1:0]     r4_q [4];
    logic [LW-1:0]           r5_lhs, r5_rhs;
    logic                    r6_hit;

    assign w_mext = MXW'(r3_m);

    // tolerance squared, settles long before an item needs it
    always_ff @(posedge i_clk) begin
        r_tt <= i_tol * i_tol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_back <= {r_back[4:0], i_ctl.back_facing};

            for (int i = 0; i < 3; i++) begin
                r1_abs[i] <= i_det[i][DTW-1] ? DTW'(-i_det[i]) : DTW'(i_det[i]);
            end
            r1_sum <= SUMW'(i_det[0]) + SUMW'(i_det[1]) + SUMW'(i_det[2]);
            r1_dd  <= i_dd;

            r2_sa <= MW'(r1_abs[0]) + MW'(r1_abs[1]) + MW'(r1_abs[2]);
            r2_as <= r1_sum[SUMW-1] ? SUMW'(-r1_sum) : SUMW'(r1_sum);
            r2_dd <= r1_dd;

            r3_m  <= r2_sa - MW'(r2_as);
            r3_dd <= r2_dd;

            // mismatch at or above 2^LIM can never pass
            r4_big <= (w_mext >> LIM) != '0;
            r4_ll  <= w_mext[MH-1:0] * w_mext[MH-1:0];
            r4_lh  <= w_mext[MH-1:0] * w_mext[LIM-1:MH];
            r4_hh  <= w_mext[LIM-1:MH] * w_mext[LIM-1:MH];
            r4_q[0] <= r_tt[TOL_W-1:0] * r3_dd[CW-1:0];
            r4_q[1] <= r_tt[TOL_W-1:0] * r3_dd[DDW-1:CW];
            r4_q[2] <= r_tt[TTW-1:TOL_W] * r3_dd[CW-1:0];
            r4_q[3] <= r_tt[TTW-1:TOL_W] * r3_dd[DDW-1:CW];

            r5_big <= r4_big;
            r5_lhs <= (LW'(r4_hh) << (2 * MH)) + (LW'(r4_lh) << (MH + 1)) + LW'(r4_ll);
            r5_rhs <= ((LW'(r4_q[3]) << (TOL_W + CW)) + (LW'(r4_q[2]) << TOL_W)
                      + (LW'(r4_q[1]) << CW) + LW'(r4_q[0])) << SH;

            r6_hit <= ~r_back[4] & ~r5_big & (r5_lhs < r5_rhs);
        end
    end

    assign o_ctl.valid       = r_vld[5];
    assign o_ctl.back_facing = r_back[5];
    assign o_hit             = r6_hit;

endmodule
`default_nettype wire

[rtl/core/ray_triangle_area_test.sv]
// ray triangle area test: top level with stream ports and tolerance register
// an input transfer reaches the output port through the geometry stages, the compare stages and the output register
// throughput: one item per cycle, sustained while the output side keeps taking
// the 11 compute stages and the output register all advance on one enable
// reset clears every valid bit and loads area_tolerance with 1
`default_nettype none
module ray_triangle_area_test #(
    parameter int COORD_WIDTH   = 21,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // vertex_one, vertex_two, vertex_three, ray_origin, ray_direction,
    // surface_normal, 63 bits each from bit 0 up, then zero fill
    input  wire logic [rtat_pkg::S_DATA_W-1:0] i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // hit in bit 0, zero fill above
    output logic [rtat_pkg::M_DATA_W-1:0]      o_m_tdata,
    // back_facing
    output logic                               o_m_tuser,
    input  wire logic                          i_cfg_we,
    input  wire logic [rtat_pkg::TOL_W-1:0]    i_cfg_wdata
);
    import rtat_pkg::*;

    localparam int DTW = 3 * COORD_WIDTH + 7;

    logic                    w_en;
    t_ctl                    w_geom_ctl;
    t_ctl                    w_cmp_ctl;
    logic signed [DTW-1:0]   w_det [3];
    logic [2*COORD_WIDTH-1:0] w_dd;
    logic                    w_hit;

    logic [TOL_W-1:0]        r_tol;
    logic                    r_o_valid;
    logic                    r_hit;
    logic                    r_back;

    // whole pipeline moves when the output slot is free or being emptied
    assign w_en       = ~r_o_valid | i_m_tready;
    assign o_s_tready = w_en;

    // area tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // front: relative vertices, facing dot, cross products, determinants
    rtat_geom #(
        .CW (COORD_WIDTH)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_ctl   (w_geom_ctl),
        .o_det   (w_det),
        .o_dd    (w_dd)
    );

    // back: area mismatch squared against tolerance squared times |d|^2
    rtat_cmp #(
        .CW (COORD_WIDTH),
        .FB (FRACTION_BITS)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_geom_ctl),
        .i_det   (w_det),
        .i_dd    (w_dd),
        .i_tol   (r_tol),
        .o_ctl   (w_cmp_ctl),
        .o_hit   (w_hit)
    );

    // output register, holds while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_cmp_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit  <= w_hit;
            r_back <= w_cmp_ctl.back_facing;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(M_DATA_W-1){1'b0}}, r_hit};
    assign o_m_tuser  = r_back;

    // a skipped test never reports a hit
    a_back_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> !o_m_tdata[0])
        else $error("hit reported on back facing item");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    // a finished item waiting behind a stalled output is not dropped
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && w_cmp_ctl.valid) |=> w_cmp_ctl.valid)
        else $error("pipeline item lost during stall");

    // a transfer taken in while stalled cannot happen
    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while output stalled");

endmodule
`default_nettype wire
